// File: design/cbd_pkg.sv
package cbd_pkg;

  // Block queue depth between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int PIX_PER_BLK = 16;
  localparam int PIX_W       = $clog2(PIX_PER_BLK);
  localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(PIX_PER_BLK - 1);

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // One classified block: four-entry palette plus its selectors
  typedef struct packed {
    logic [3:0][7:0] red;
    logic [3:0][7:0] green;
    logic [3:0][7:0] blue;
    logic            opaque3;
    logic [31:0]     index_bits;
  } blk_entry_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic             busy;
    logic [PIX_W-1:0] pix;
  } back_status_t;

endpackage

// File: design/cbd_front.sv
module cbd_front (
  input  logic               in_valid,
  input  logic [15:0]        in_endpoint_a,
  input  logic [15:0]        in_endpoint_b,
  input  logic [31:0]        in_index_bits,
  input  logic               q_full,
  output logic               in_stall,
  output logic               q_push,
  output cbd_pkg::blk_entry_t q_data
);
  import cbd_pkg::*;

  // floor(x/3) for x <= 765 via reciprocal 683/2048
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] prod;
    prod = x * 10'd683;
    return prod[18:11];
  endfunction

  logic       four_color;
  logic [7:0] c0 [3];
  logic [7:0] c1 [3];
  logic [7:0] c2 [3];
  logic [7:0] c3 [3];

  // Widen RGB565 endpoints by plain shift
  assign c0[0] = {in_endpoint_a[15:11], 3'b000};
  assign c0[1] = {in_endpoint_a[10:5], 2'b00};
  assign c0[2] = {in_endpoint_a[4:0], 3'b000};
  assign c1[0] = {in_endpoint_b[15:11], 3'b000};
  assign c1[1] = {in_endpoint_b[10:5], 2'b00};
  assign c1[2] = {in_endpoint_b[4:0], 3'b000};

  assign four_color = in_endpoint_a > in_endpoint_b;

  // Interpolated colors per channel
  always_comb begin
    logic [9:0] sum_a2b;
    logic [9:0] sum_ab2;
    logic [8:0] sum_ab;
    for (int ch = 0; ch < 3; ch++) begin
      sum_a2b = {1'b0, c0[ch], 1'b0} + {2'b00, c1[ch]};
      sum_ab2 = {2'b00, c0[ch]} + {1'b0, c1[ch], 1'b0};
      sum_ab  = {1'b0, c0[ch]} + {1'b0, c1[ch]};
      c2[ch]  = four_color ? div3(sum_a2b) : sum_ab[8:1];
      c3[ch]  = div3(sum_ab2);
    end
  end

  // Pack the classified block for the queue
  always_comb begin
    q_data.red        = {c3[0], c2[0], c1[0], c0[0]};
    q_data.green      = {c3[1], c2[1], c1[1], c0[1]};
    q_data.blue       = {c3[2], c2[2], c1[2], c0[2]};
    q_data.opaque3    = four_color;
    q_data.index_bits = in_index_bits;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// File: design/cbd_queue.sv
module cbd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cbd_pkg::blk_entry_t push_data,
  input  logic                pop,
  output logic                full,
  output logic                valid,
  output cbd_pkg::blk_entry_t head
);
  import cbd_pkg::*;

  blk_entry_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full  = count_r == QCNT_W'(QUEUE_DEPTH);
  assign valid = count_r != '0;
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/cbd_back.sv
module cbd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  cbd_pkg::blk_entry_t   q_head,
  output logic                  q_pop,
  output cbd_pkg::back_status_t status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  output logic [3:0]            out_pixel_number,
  output logic                  out_last_pixel
);
  import cbd_pkg::*;

  logic [PIX_W-1:0] pix_cnt_r, pix_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       red_r, green_r, blue_r, alpha_r;
  logic [3:0]       num_r;
  logic             last_r;
  logic             load;
  logic [1:0]       sel;

  // Output register takes a pixel when empty or being drained
  assign load  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = load && (pix_cnt_r == LAST_PIX);

  // Selector for pixel p sits at bits 31-2p : 30-2p
  assign sel = q_head.index_bits[{~pix_cnt_r, 1'b1} -: 2];

  always_comb begin
    pix_cnt_nxt   = load ? pix_cnt_r + 1'b1 : pix_cnt_r;
    out_valid_nxt = load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pix_cnt_r   <= pix_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Palette lookup into the output register
  always_ff @(posedge clk) begin
    if (load) begin
      red_r   <= q_head.red[sel];
      green_r <= q_head.green[sel];
      blue_r  <= q_head.blue[sel];
      alpha_r <= (sel == 2'd3 && !q_head.opaque3) ? ALPHA_CLEAR : ALPHA_OPAQUE;
      num_r   <= pix_cnt_r;
      last_r  <= pix_cnt_r == LAST_PIX;
    end
  end

  assign status.busy = q_valid;
  assign status.pix  = pix_cnt_r;

  assign out_valid        = out_valid_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_alpha        = alpha_r;
  assign out_pixel_number = num_r;
  assign out_last_pixel   = last_r;

endmodule

// File: design/cmpr_block_decoder.sv
// Compressed 4x4 block decoder: each input item is one RGB565 endpoint pair
// with sixteen 2-bit selectors, and yields sixteen RGBA8 pixel items in
// raster order, pixel_number 0..15, last_pixel set on the sixteenth. The
// front end builds the palette in the accepting cycle and writes it into a
// two-entry block queue; the back end reads one pixel per cycle, unless
// out_stall holds it, through a registered output that sets the block rate.
// The first pixel of a block is registered from the queue head once the
// output register is empty or being drained. Up to two blocks wait in the
// queue, so input is stalled only when both entries are taken.
module cmpr_block_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_endpoint_a,
  input  logic [15:0] in_endpoint_b,
  input  logic [31:0] in_index_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [3:0]  out_pixel_number,
  output logic        out_last_pixel
);
  import cbd_pkg::*;

  logic         q_push, q_full, q_valid, q_pop;
  blk_entry_t   q_data, q_head;
  back_status_t back_st;

  cbd_front u_front (
    .in_valid      (in_valid),
    .in_endpoint_a (in_endpoint_a),
    .in_endpoint_b (in_endpoint_b),
    .in_index_bits (in_index_bits),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  cbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  cbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .status           (back_st),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_pixel_number (out_pixel_number),
    .out_last_pixel   (out_last_pixel)
  );

  // Pixel counter only leaves zero while a block is being walked
  assert property (@(posedge clk) disable iff (!rst_n)
    !back_st.busy |-> back_st.pix == '0)
    else $error("pixel counter advanced with no block queued");

  // Last flag marks exactly pixel fifteen
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_pixel == (out_pixel_number == LAST_PIX)))
    else $error("last_pixel disagrees with pixel_number");

  // A popped block is followed by pixel zero of the next one
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> back_st.pix == '0)
    else $error("pixel counter did not wrap at block end");

endmodule

// File: dv/tb_top.sv
module tb_top;
  import cbd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 28;
  localparam int DRAIN_WAIT  = 20;

  // one decoded pixel as the result channel carries it
  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [PIX_W-1:0] number;
    logic             last;
  } pixel_t;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic [15:0] in_endpoint_a = '0;
  logic [15:0] in_endpoint_b = '0;
  logic [31:0] in_index_bits = '0;
  logic        out_stall     = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [3:0]  out_pixel_number;
  logic        out_last_pixel;

  pixel_t expected_pixels[$];
  int     err_count   = 0;
  int     cycle_count = 0;
  bit     steady      = 1'b0;  // no idling on either side while set

  cmpr_block_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_endpoint_a    (in_endpoint_a),
    .in_endpoint_b    (in_endpoint_b),
    .in_index_bits    (in_index_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_pixel_number (out_pixel_number),
    .out_last_pixel   (out_last_pixel)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // random backpressure on the pixel side
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // build the palette of one block and queue its sixteen pixels
  function automatic void predict_pixels(input logic [15:0] ea, input logic [15:0] eb,
                                         input logic [31:0] sel);
    int         r[4];
    int         g[4];
    int         b[4];
    logic [7:0] alpha3;
    logic [1:0] s;
    pixel_t     px;
    // left shift only, no bit replication
    r[0] = {ea[15:11], 3'b000};
    g[0] = {ea[10:5], 2'b00};
    b[0] = {ea[4:0], 3'b000};
    r[1] = {eb[15:11], 3'b000};
    g[1] = {eb[10:5], 2'b00};
    b[1] = {eb[4:0], 3'b000};
    if (ea > eb) begin
      // four opaque colors
      r[2]   = (2 * r[0] + r[1]) / 3;
      g[2]   = (2 * g[0] + g[1]) / 3;
      b[2]   = (2 * b[0] + b[1]) / 3;
      alpha3 = ALPHA_OPAQUE;
    end else begin
      // mean plus transparent entry, equal endpoints land here
      r[2]   = (r[0] + r[1]) / 2;
      g[2]   = (g[0] + g[1]) / 2;
      b[2]   = (b[0] + b[1]) / 2;
      alpha3 = ALPHA_CLEAR;
    end
    r[3] = (r[0] + 2 * r[1]) / 3;
    g[3] = (g[0] + 2 * g[1]) / 3;
    b[3] = (b[0] + 2 * b[1]) / 3;
    for (int p = 0; p < PIX_PER_BLK; p++) begin
      s         = sel[31 - 2 * p -: 2];
      px.red    = 8'(r[s]);
      px.green  = 8'(g[s]);
      px.blue   = 8'(b[s]);
      px.alpha  = (s == 2'd3) ? alpha3 : ALPHA_OPAQUE;
      px.number = PIX_W'(p);
      px.last   = (p == PIX_PER_BLK - 1);
      expected_pixels.push_back(px);
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // compare every accepted pixel with the oldest expectation
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel %0d", out_pixel_number);
        err_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
        check_field("alpha", want.alpha, out_alpha);
        check_field("pixel_number", want.number, out_pixel_number);
        check_field("last_pixel", want.last, out_last_pixel);
      end
    end
  end

  // drive one block, with random idle cycles ahead of it
  task automatic send_block(input logic [15:0] ea, input logic [15:0] eb,
                            input logic [31:0] sel);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_endpoint_a <= ea;
    in_endpoint_b <= eb;
    in_index_bits <= sel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixels(ea, eb, sel);
  endtask

  // random block, mostly with a chosen endpoint order
  task automatic send_random_block();
    logic [15:0] ea;
    logic [15:0] eb;
    logic [15:0] tmp;
    logic [31:0] sel;
    ea  = 16'($urandom);
    eb  = 16'($urandom);
    sel = $urandom;
    case ($urandom_range(9))
      0: eb = ea;
      1, 2, 3, 4: begin
        if (ea < eb) begin
          tmp = ea;
          ea  = eb;
          eb  = tmp;
        end
      end
      default: begin
        if (ea > eb) begin
          tmp = ea;
          ea  = eb;
          eb  = tmp;
        end
      end
    endcase
    send_block(ea, eb, sel);
  endtask

  // extremes, both modes, equal endpoints, every selector value
  task automatic test_corner_blocks();
    send_block(16'hFFFF, 16'h0000, 32'h0000_0000);
    send_block(16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    send_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
    send_block(16'h0000, 16'hFFFF, 32'h1B1B_1B1B);
    send_block(16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    send_block(16'h0000, 16'h0000, 32'hE4E4_E4E4);
    send_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_block(16'hF800, 16'h07E0, 32'hE4E4_E4E4);
    send_block(16'h07E0, 16'hF800, 32'hE4E4_E4E4);
    send_block(16'h001F, 16'hF800, 32'hAAAA_AAAA);
    send_block(16'hF81F, 16'h07E0, 32'h5555_5555);
    send_block(16'h8000, 16'h7FFF, 32'hC000_0003);
    send_block(16'h7FFF, 16'h8000, 32'h3FFF_FFFC);
    send_block(16'h0001, 16'h0000, 32'hE4E4_E4E4);
    send_block(16'h0000, 16'h0001, 32'hE4E4_E4E4);
  endtask

  task automatic test_random_blocks(input int count);
    for (int i = 0; i < count; i++) send_random_block();
  endtask

  // back-to-back blocks with no idling on either side
  task automatic test_steady_burst(input int count);
    steady = 1'b1;
    for (int i = 0; i < count; i++) send_random_block();
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_blocks();
    test_random_blocks(100);
    test_steady_burst(40);
    test_random_blocks(60);

    // drain the remaining pixels
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d pixels never arrived", expected_pixels.size());
      err_count++;
    end

    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
